// ===== hdl/gdc_pkg.sv =====
`default_nettype none
package gdc_pkg;

	localparam logic [1:0] KIND_FRAME = 2'd0;
	localparam logic [1:0] KIND_FWD_WR = 2'd1;
	localparam logic [1:0] KIND_STAT_RD = 2'd2;
	localparam logic [1:0] KIND_RSVD = 2'd3;

	localparam logic [1:0] VERDICT_PASS = 2'd0;
	localparam logic [1:0] VERDICT_DROP = 2'd1;
	localparam logic [1:0] VERDICT_REDIRECT = 2'd2;
	localparam logic [1:0] VERDICT_ABORT = 2'd3;

	localparam logic [15:0] ETYPE_V4 = 16'h0800;
	localparam logic [15:0] ETYPE_V6 = 16'h86DD;
	localparam logic [15:0] GTP_UDP_PORT = 16'd2152;
	localparam logic [7:0] GTP_FLAGS = 8'h30;
	localparam logic [7:0] GTP_TYPE_TPDU = 8'hFF;
	localparam logic [7:0] IP_PROTO_UDP = 8'd17;

	// Summary of a parsed frame, valid on the cycle its last byte is taken.
	typedef struct packed {
		logic ok;
		logic v6;
		logic [9:0] strip;
		logic [15:0] glen;
		logic [31:0] teid;
	} frm_t;

endpackage
`default_nettype wire

// ===== hdl/gdc_if.sv =====
`default_nettype none
interface gdc_in_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic last_byte;
	logic [15:0] ingress_port;
	logic [5:0] entry_slot;
	logic [31:0] entry_teid;
	logic entry_valid;
	logic [15:0] entry_out_port;
	logic [47:0] entry_dst_mac;
	logic [47:0] entry_src_mac;

	modport source(output valid, kind, data_byte, last_byte, ingress_port, entry_slot,
		entry_teid, entry_valid, entry_out_port, entry_dst_mac, entry_src_mac,
		input ready);
	modport sink(input valid, kind, data_byte, last_byte, ingress_port, entry_slot,
		entry_teid, entry_valid, entry_out_port, entry_dst_mac, entry_src_mac,
		output ready);
endinterface

interface gdc_out_if;
	logic valid;
	logic ready;
	logic [1:0] verdict;
	logic [15:0] out_port;
	logic [47:0] new_dst_mac;
	logic [47:0] new_src_mac;
	logic [15:0] new_ethertype;
	logic [9:0] strip_bytes;
	logic [31:0] tunnel_id;
	logic stat_found;
	logic [63:0] stat_packets;
	logic [63:0] stat_bytes;
	logic [63:0] stat_misses;

	modport source(output valid, verdict, out_port, new_dst_mac, new_src_mac,
		new_ethertype, strip_bytes, tunnel_id, stat_found, stat_packets, stat_bytes,
		stat_misses, input ready);
	modport sink(input valid, verdict, out_port, new_dst_mac, new_src_mac,
		new_ethertype, strip_bytes, tunnel_id, stat_found, stat_packets, stat_bytes,
		stat_misses, output ready);
endinterface
`default_nettype wire

// ===== hdl/gdc_ram.sv =====
`default_nettype none
module gdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/gdc_parser.sv =====
`default_nettype none
module gdc_parser
	import gdc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic [7:0] data_byte,
	input wire logic last_byte,
	input wire logic [15:0] ingress_port,
	input wire logic [15:0] expected_ingress,
	output frm_t frame
);
	logic [15:0] pos_q, pos_n, pos_inc;
	logic [15:0] etype_q, etype_n;
	logic [3:0] ihl_q, ihl_n;
	logic [31:0] hist_q, hist_n;
	logic rej_q, rej_n;
	logic [15:0] glen_q, glen_n;
	logic [31:0] teid_q, teid_n;
	logic hdone_q, hdone_n;
	logic [15:0] lo16;
	logic [7:0] ustart, ustart_fin;

	always_comb begin
		pos_inc = (pos_q != 16'hFFFF) ? pos_q + 16'd1 : pos_q;
		pos_n = pos_inc;
		etype_n = etype_q;
		ihl_n = ihl_q;
		hist_n = hist_q;
		rej_n = rej_q;
		glen_n = glen_q;
		teid_n = teid_q;
		hdone_n = hdone_q;
		lo16 = 16'd0;
		ustart = 8'd0;
		if (!hdone_q && !rej_q) begin
			hist_n = {hist_q[23:0], data_byte};
			lo16 = hist_n[15:0];
			if (pos_q == 16'd13) begin
				etype_n = lo16;
				if (lo16 != ETYPE_V4 && lo16 != ETYPE_V6) begin
					rej_n = 1'b1;
				end
			end else if (pos_q >= 16'd14) begin
				if (etype_q == ETYPE_V4) begin
					if (pos_q == 16'd14) begin
						ihl_n = data_byte[3:0];
						if (ihl_n < 4'd5) begin
							rej_n = 1'b1;
						end
					end else if (pos_q == 16'd21) begin
						if ((lo16 & 16'h3FFF) != 16'd0) begin
							rej_n = 1'b1;
						end
					end else if (pos_q == 16'd23) begin
						if (data_byte != IP_PROTO_UDP) begin
							rej_n = 1'b1;
						end
					end
				end else if (pos_q == 16'd20 && data_byte != IP_PROTO_UDP) begin
					rej_n = 1'b1;
				end
				ustart = (etype_q == ETYPE_V6) ? 8'd54 : 8'd14 + {2'b00, ihl_n, 2'b00};
				if (!rej_n) begin
					if (pos_q == 16'(ustart) + 16'd3) begin
						if (lo16 != GTP_UDP_PORT) begin
							rej_n = 1'b1;
						end
					end else if (pos_q == 16'(ustart) + 16'd9) begin
						if (lo16 != {GTP_FLAGS, GTP_TYPE_TPDU}) begin
							rej_n = 1'b1;
						end
					end else if (pos_q == 16'(ustart) + 16'd11) begin
						glen_n = lo16;
					end else if (pos_q == 16'(ustart) + 16'd15) begin
						teid_n = hist_n;
						hdone_n = 1'b1;
						pos_n = 16'd0;
					end
				end
			end
		end
	end

	always_comb begin
		ustart_fin = (etype_n == ETYPE_V6) ? 8'd54 : 8'd14 + {2'b00, ihl_n, 2'b00};
		frame.ok = hdone_n && !rej_n
			&& (expected_ingress == 16'd0 || ingress_port == expected_ingress)
			&& (glen_n <= pos_n);
		frame.v6 = (etype_n == ETYPE_V6);
		frame.strip = 10'(ustart_fin) + 10'd2;
		frame.glen = glen_n;
		frame.teid = teid_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			etype_q <= '0;
			ihl_q <= '0;
			hist_q <= '0;
			rej_q <= 1'b0;
			glen_q <= '0;
			teid_q <= '0;
			hdone_q <= 1'b0;
		end else if (en) begin
			if (last_byte) begin
				pos_q <= '0;
				etype_q <= '0;
				ihl_q <= '0;
				hist_q <= '0;
				rej_q <= 1'b0;
				glen_q <= '0;
				teid_q <= '0;
				hdone_q <= 1'b0;
			end else begin
				pos_q <= pos_n;
				etype_q <= etype_n;
				ihl_q <= ihl_n;
				hist_q <= hist_n;
				rej_q <= rej_n;
				glen_q <= glen_n;
				teid_q <= teid_n;
				hdone_q <= hdone_n;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/gtpu_decap_classifier_core.sv =====
// Frame bytes, table writes and ignored kinds are taken one per cycle while the core is idle.
// The last byte of a frame that parses ok starts a scan of the forwarding RAM, then of the
// statistics RAM; a statistics read scans only the statistics RAM, and a rejected frame skips
// the scan. A live slot is read, then compared; a match ends the scan of that RAM.
// No input is taken during a scan; the result register holds until the sink takes it.
// Reset clears the parser, the valid bits of both tables and the result valid; no clearing pass.
`default_nettype none
module gtpu_decap_classifier_core
	import gdc_pkg::*;
#(
	parameter int FWD_DEPTH = 64,
	parameter int STATS_DEPTH = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [15:0] cfg_data,
	gdc_in_if.sink in_ch,
	gdc_out_if.source out_ch
);
	localparam int FAW = (FWD_DEPTH > 1) ? $clog2(FWD_DEPTH) : 1;
	localparam int SAW = (STATS_DEPTH > 1) ? $clog2(STATS_DEPTH) : 1;
	localparam int MAXD = (FWD_DEPTH > STATS_DEPTH) ? FWD_DEPTH : STATS_DEPTH;
	localparam int IW = $clog2(MAXD + 1);
	localparam int FW = 32 + 16 + 48 + 48;
	localparam int SW = 32 + 192;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_FRD  = 7'b0000010,
		ST_FCMP = 7'b0000100,
		ST_SRD  = 7'b0001000,
		ST_SCMP = 7'b0010000,
		ST_EMIT = 7'b0100000,
		ST_HOLD = 7'b1000000
	} state_t;

	state_t state_q;
	logic [15:0] exp_q;
	logic [IW-1:0] idx_q;
	logic [FWD_DEPTH-1:0] fwd_valid_q;
	logic [STATS_DEPTH-1:0] stats_valid_q;
	logic query_q, ok_q, hit_q, found_q, free_ok_q, v6_q;
	logic [SAW-1:0] free_q;
	logic [31:0] teid_q;
	logic [15:0] glen_q, fport_q;
	logic [9:0] strip_q;
	logic [47:0] dmac_q, smac_q;
	logic [191:0] cnt_q;

	logic in_acc, byte_acc;
	frm_t frame;
	logic [FAW-1:0] fidx, fwaddr;
	logic [SAW-1:0] sidx;
	logic [FW-1:0] frdata;
	logic [SW-1:0] srdata, swdata;
	logic fwe, swe, slot_ok;
	logic [SAW-1:0] swaddr;
	logic [63:0] pk_new, by_new, ms_new;

	assign fidx = idx_q[FAW-1:0];
	assign sidx = idx_q[SAW-1:0];
	assign fwaddr = FAW'(in_ch.entry_slot);
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign byte_acc = in_acc && (in_ch.kind == KIND_FRAME);
	assign slot_ok = {26'd0, in_ch.entry_slot} < 32'(FWD_DEPTH);
	assign fwe = in_acc && (in_ch.kind == KIND_FWD_WR) && slot_ok;

	gdc_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.en(byte_acc),
		.data_byte(in_ch.data_byte),
		.last_byte(in_ch.last_byte),
		.ingress_port(in_ch.ingress_port),
		.expected_ingress(exp_q),
		.frame(frame)
	);

	gdc_ram #(.WIDTH(FW), .DEPTH(FWD_DEPTH)) u_fwd_ram (
		.clk(clk),
		.we(fwe),
		.waddr(fwaddr),
		.wdata({in_ch.entry_teid, in_ch.entry_out_port, in_ch.entry_dst_mac,
			in_ch.entry_src_mac}),
		.raddr(fidx),
		.rdata(frdata)
	);

	gdc_ram #(.WIDTH(SW), .DEPTH(STATS_DEPTH)) u_stats_ram (
		.clk(clk),
		.we(swe),
		.waddr(swaddr),
		.wdata(swdata),
		.raddr(sidx),
		.rdata(srdata)
	);

	// Counter updates: a hit adds a packet and its length, a miss adds one miss.
	// A newly allocated entry starts from zero, so the base is cleared on allocation.
	always_comb begin
		logic [191:0] base;
		base = (state_q == ST_SCMP) ? srdata[191:0] : 192'd0;
		pk_new = base[63:0] + (hit_q ? 64'd1 : 64'd0);
		by_new = base[127:64] + (hit_q ? {48'd0, glen_q} : 64'd0);
		ms_new = base[191:128] + (hit_q ? 64'd0 : 64'd1);
		swdata = {teid_q, ms_new, by_new, pk_new};
		swe = 1'b0;
		swaddr = sidx;
		if (!query_q) begin
			if (state_q == ST_SCMP && srdata[SW-1:192] == teid_q) begin
				swe = 1'b1;
			end else if (state_q == ST_SRD && idx_q == IW'(STATS_DEPTH) && free_ok_q) begin
				swe = 1'b1;
				swaddr = free_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
		end else if (cfg_we) begin
			exp_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			fwd_valid_q <= '0;
			stats_valid_q <= '0;
			query_q <= 1'b0;
			ok_q <= 1'b0;
			hit_q <= 1'b0;
			found_q <= 1'b0;
			free_ok_q <= 1'b0;
		end else begin
			if (fwe) begin
				fwd_valid_q[fwaddr] <= in_ch.entry_valid;
			end
			if (swe) begin
				stats_valid_q[swaddr] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					hit_q <= 1'b0;
					found_q <= 1'b0;
					free_ok_q <= 1'b0;
					if (byte_acc && in_ch.last_byte) begin
						query_q <= 1'b0;
						ok_q <= frame.ok;
						teid_q <= frame.teid;
						glen_q <= frame.glen;
						v6_q <= frame.v6;
						strip_q <= frame.strip;
						state_q <= frame.ok ? ST_FRD : ST_EMIT;
					end else if (in_acc && in_ch.kind == KIND_STAT_RD) begin
						query_q <= 1'b1;
						ok_q <= 1'b0;
						teid_q <= in_ch.entry_teid;
						cnt_q <= '0;
						state_q <= ST_SRD;
					end
				end
				ST_FRD: begin
					if (idx_q == IW'(FWD_DEPTH)) begin
						idx_q <= '0;
						state_q <= ST_SRD;
					end else if (fwd_valid_q[fidx]) begin
						state_q <= ST_FCMP;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_FCMP: begin
					if (frdata[FW-1:112] == teid_q) begin
						hit_q <= 1'b1;
						fport_q <= frdata[111:96];
						dmac_q <= frdata[95:48];
						smac_q <= frdata[47:0];
						idx_q <= '0;
						state_q <= ST_SRD;
					end else begin
						idx_q <= idx_q + IW'(1);
						state_q <= ST_FRD;
					end
				end
				ST_SRD: begin
					if (idx_q == IW'(STATS_DEPTH)) begin
						state_q <= ST_EMIT;
					end else if (stats_valid_q[sidx]) begin
						state_q <= ST_SCMP;
					end else begin
						if (!free_ok_q) begin
							free_ok_q <= 1'b1;
							free_q <= sidx;
						end
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_SCMP: begin
					if (srdata[SW-1:192] == teid_q) begin
						found_q <= 1'b1;
						cnt_q <= srdata[191:0];
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + IW'(1);
						state_q <= ST_SRD;
					end
				end
				ST_EMIT: begin
					if (!out_ch.valid || out_ch.ready) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_ch.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register; it loads when a scan ends (or a rejected frame is done) and the previous result has left.
	logic load;
	assign load = (state_q == ST_EMIT && (!out_ch.valid || out_ch.ready))
		|| (state_q == ST_HOLD && out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (load) begin
			out_ch.valid <= 1'b1;
		end else if (out_ch.ready) begin
			out_ch.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_ch.verdict <= VERDICT_PASS;
			out_ch.out_port <= '0;
			out_ch.new_dst_mac <= '0;
			out_ch.new_src_mac <= '0;
			out_ch.new_ethertype <= '0;
			out_ch.strip_bytes <= '0;
			out_ch.tunnel_id <= '0;
			out_ch.stat_found <= 1'b0;
			out_ch.stat_packets <= '0;
			out_ch.stat_bytes <= '0;
			out_ch.stat_misses <= '0;
			if (query_q) begin
				out_ch.tunnel_id <= teid_q;
				out_ch.stat_found <= found_q;
				out_ch.stat_packets <= found_q ? cnt_q[63:0] : 64'd0;
				out_ch.stat_bytes <= found_q ? cnt_q[127:64] : 64'd0;
				out_ch.stat_misses <= found_q ? cnt_q[191:128] : 64'd0;
			end else if (ok_q) begin
				out_ch.tunnel_id <= teid_q;
				if (hit_q) begin
					out_ch.verdict <= (fport_q != 16'd0) ? VERDICT_REDIRECT : VERDICT_ABORT;
					out_ch.out_port <= fport_q;
					out_ch.new_dst_mac <= dmac_q;
					out_ch.new_src_mac <= smac_q;
					out_ch.new_ethertype <= v6_q ? ETYPE_V6 : ETYPE_V4;
					out_ch.strip_bytes <= strip_q;
				end else begin
					out_ch.verdict <= VERDICT_DROP;
				end
			end
		end
	end

	a_last_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_acc && in_ch.last_byte) |=> (state_q != ST_IDLE))
		else $error("last byte did not start result work");
	a_fcmp_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FCMP) |-> fwd_valid_q[fidx])
		else $error("forwarding compare on a dead slot");
	a_stats_wr_when: assert property (@(posedge clk) disable iff (!arst_n)
		swe |-> (!query_q && (state_q == ST_SCMP || state_q == ST_SRD)))
		else $error("statistics write outside frame scan");
	a_no_drop_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> out_ch.valid)
		else $error("result lost while stalled");
endmodule
`default_nettype wire

// ===== tb/gdc_checker.sv =====
`timescale 1ns / 1ps
module gdc_checker
	import gdc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [15:0] cfg_data,
	gdc_in_if in_ch,
	gdc_out_if out_ch,
	output int errors,
	output int pending
);

	typedef struct packed {
		logic [1:0] verdict;
		logic [15:0] out_port;
		logic [47:0] dmac;
		logic [47:0] smac;
		logic [15:0] etype;
		logic [9:0] strip;
		logic [31:0] teid;
		logic found;
		logic [63:0] pkts;
		logic [63:0] bytes;
		logic [63:0] misses;
	} verdict_t;

	verdict_t verdict_q[$];

	logic [15:0] ingress_req;
	logic [15:0] pos;
	logic [15:0] etype;
	logic [3:0] ihl;
	logic [63:0] shreg;
	logic rejected;
	logic hdr_done;
	logic [15:0] glen;
	logic [31:0] teid;
	logic fwd_live[64];
	logic [31:0] fwd_teid[64];
	logic [15:0] fwd_port[64];
	logic [47:0] fwd_dmac[64];
	logic [47:0] fwd_smac[64];
	logic st_live[64];
	logic [31:0] st_teid[64];
	logic [63:0] st_pkts[64];
	logic [63:0] st_bytes[64];
	logic [63:0] st_miss[64];

	assign pending = verdict_q.size();

	function automatic logic [9:0] udp_off();
		if (etype == ETYPE_V6)
			return 10'd54;
		return 10'd14 + 10'(ihl) * 10'd4;
	endfunction

	function automatic int stats_lookup(logic [31:0] key, bit alloc);
		for (int i = 0; i < 64; i++)
			if (st_live[i] && st_teid[i] == key)
				return i;
		if (alloc)
			for (int i = 0; i < 64; i++)
				if (!st_live[i]) begin
					st_live[i] = 1;
					st_teid[i] = key;
					st_pkts[i] = 0;
					st_bytes[i] = 0;
					st_miss[i] = 0;
					return i;
				end
		return -1;
	endfunction

	task automatic restart_frame();
		pos = 0;
		etype = 0;
		ihl = 0;
		shreg = 0;
		rejected = 0;
		hdr_done = 0;
		glen = 0;
		teid = 0;
	endtask

	task automatic take_byte(logic [7:0] b);
		logic [15:0] lo;
		int p;
		int u;
		p = pos;
		if (hdr_done || rejected) begin
			if (pos != 16'hFFFF)
				pos++;
			return;
		end
		shreg = {shreg[55:0], b};
		lo = shreg[15:0];
		if (p == 13) begin
			etype = lo;
			if (lo != ETYPE_V4 && lo != ETYPE_V6)
				rejected = 1;
		end else if (p >= 14) begin
			if (etype == ETYPE_V4) begin
				if (p == 14) begin
					ihl = b[3:0];
					if (ihl < 5)
						rejected = 1;
				end else if (p == 21) begin
					if (lo[13:0] != 0)
						rejected = 1;
				end else if (p == 23 && b != IP_PROTO_UDP) begin
					rejected = 1;
				end
			end else if (p == 20 && b != IP_PROTO_UDP) begin
				rejected = 1;
			end
			if (!rejected) begin
				u = udp_off();
				if (p == u + 3) begin
					if (lo != GTP_UDP_PORT)
						rejected = 1;
				end else if (p == u + 9) begin
					if (lo != {GTP_FLAGS, GTP_TYPE_TPDU})
						rejected = 1;
				end else if (p == u + 11) begin
					glen = lo;
				end else if (p == u + 15) begin
					teid = shreg[31:0];
					hdr_done = 1;
					pos = 0;
					return;
				end
			end
		end
		if (pos != 16'hFFFF)
			pos++;
	endtask

	function automatic verdict_t classify(logic [15:0] port);
		verdict_t r;
		int hit;
		int s;
		r = '0;
		hit = -1;
		if (!hdr_done || rejected)
			return r;
		if (ingress_req != 0 && port != ingress_req)
			return r;
		if (glen > pos)
			return r;
		for (int i = 0; i < 64; i++)
			if (hit < 0 && fwd_live[i] && fwd_teid[i] == teid)
				hit = i;
		r.teid = teid;
		s = stats_lookup(teid, 1);
		if (hit < 0) begin
			if (s >= 0)
				st_miss[s]++;
			r.verdict = VERDICT_DROP;
			return r;
		end
		if (s >= 0) begin
			st_pkts[s]++;
			st_bytes[s] += 64'(glen);
		end
		r.out_port = fwd_port[hit];
		r.dmac = fwd_dmac[hit];
		r.smac = fwd_smac[hit];
		r.etype = (etype == ETYPE_V6) ? ETYPE_V6 : ETYPE_V4;
		r.strip = udp_off() + 10'd2;
		r.verdict = (fwd_port[hit] != 0) ? VERDICT_REDIRECT : VERDICT_ABORT;
		return r;
	endfunction

	task automatic cmp(string name, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			$error("%s: expected %0h, got %0h", name, e, a);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t r;
		verdict_t e;
		int s;
		if (!arst_n) begin
			ingress_req = 0;
			restart_frame();
			for (int i = 0; i < 64; i++) begin
				fwd_live[i] = 0;
				st_live[i] = 0;
			end
			verdict_q.delete();
			errors = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				r = {out_ch.verdict, out_ch.out_port, out_ch.new_dst_mac, out_ch.new_src_mac,
					out_ch.new_ethertype, out_ch.strip_bytes, out_ch.tunnel_id,
					out_ch.stat_found, out_ch.stat_packets, out_ch.stat_bytes,
					out_ch.stat_misses};
				if (verdict_q.size() == 0) begin
					$error("unexpected result transaction, tunnel_id %0h", r.teid);
					errors++;
				end else begin
					e = verdict_q.pop_front();
					cmp("verdict", e.verdict, r.verdict);
					cmp("out_port", e.out_port, r.out_port);
					cmp("new_dst_mac", e.dmac, r.dmac);
					cmp("new_src_mac", e.smac, r.smac);
					cmp("new_ethertype", e.etype, r.etype);
					cmp("strip_bytes", e.strip, r.strip);
					cmp("tunnel_id", e.teid, r.teid);
					cmp("stat_found", e.found, r.found);
					cmp("stat_packets", e.pkts, r.pkts);
					cmp("stat_bytes", e.bytes, r.bytes);
					cmp("stat_misses", e.misses, r.misses);
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				case (in_ch.kind)
					KIND_FRAME: begin
						take_byte(in_ch.data_byte);
						if (in_ch.last_byte) begin
							verdict_q.push_back(classify(in_ch.ingress_port));
							restart_frame();
						end
					end
					KIND_FWD_WR: begin
						fwd_live[in_ch.entry_slot] = in_ch.entry_valid;
						fwd_teid[in_ch.entry_slot] = in_ch.entry_teid;
						fwd_port[in_ch.entry_slot] = in_ch.entry_out_port;
						fwd_dmac[in_ch.entry_slot] = in_ch.entry_dst_mac;
						fwd_smac[in_ch.entry_slot] = in_ch.entry_src_mac;
					end
					KIND_STAT_RD: begin
						r = '0;
						r.teid = in_ch.entry_teid;
						s = stats_lookup(in_ch.entry_teid, 0);
						if (s >= 0) begin
							r.found = 1;
							r.pkts = st_pkts[s];
							r.bytes = st_bytes[s];
							r.misses = st_miss[s];
						end
						verdict_q.push_back(r);
					end
					default: begin
					end
				endcase
			end
			if (cfg_we)
				ingress_req = cfg_data;
		end
	end

endmodule

// ===== tb/tb_gtpu_decap_classifier_core.sv =====
`timescale 1ns / 1ps
module tb_gtpu_decap_classifier_core;
	import gdc_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [15:0] cfg_data = 0;
	int errors;
	int pending;
	int cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	bit slow_rx = 0;

	gdc_in_if in_ch();
	gdc_out_if out_ch();

	gtpu_decap_classifier_core u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	gdc_checker u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_ch(in_ch), .out_ch(out_ch), .errors(errors), .pending(pending)
	);

	// A small pool of tunnel ids keeps table hits and statistics reads frequent.
	logic [31:0] teid_pool[8] = '{32'h0, 32'hFFFFFFFF, 32'h1, 32'h12345678,
		32'h80000000, 32'hA5A5A5A5, 32'h00C0FFEE, 32'h7FFFFFFF};
	logic [15:0] port_pool[4] = '{16'd0, 16'd1, 16'hFFFF, 16'h1234};
	logic [15:0] cur_ingress;
	logic [7:0] frame[$];

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: long hold-off when requested, else frequent or occasional random stalls.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 0;
		end else if (slow_rx)
			out_ch.ready <= ($urandom_range(0, 3) == 0);
		else
			out_ch.ready <= ($urandom_range(0, 4) != 0);
	end

	initial begin
		in_ch.valid = 0;
		in_ch.kind = KIND_FRAME;
		in_ch.data_byte = 0;
		in_ch.last_byte = 0;
		in_ch.ingress_port = 0;
		in_ch.entry_slot = 0;
		in_ch.entry_teid = 0;
		in_ch.entry_valid = 0;
		in_ch.entry_out_port = 0;
		in_ch.entry_dst_mac = 0;
		in_ch.entry_src_mac = 0;
		out_ch.ready = 0;
	end

	// Presents one transaction and holds it until accepted, with bursty gaps.
	task automatic send(logic [1:0] k, logic [7:0] b, logic lst, logic [5:0] slot,
			logic [31:0] id, logic ev, logic [15:0] op, logic [47:0] dm, logic [47:0] sm);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
		if (gap_left > 0) begin
			in_ch.valid <= 0;
			repeat (gap_left) @(posedge clk);
		end
		gap_left = 0;
		burst_left--;
		in_ch.valid <= 1;
		in_ch.kind <= k;
		in_ch.data_byte <= b;
		in_ch.last_byte <= lst;
		in_ch.ingress_port <= cur_ingress;
		in_ch.entry_slot <= slot;
		in_ch.entry_teid <= id;
		in_ch.entry_valid <= ev;
		in_ch.entry_out_port <= op;
		in_ch.entry_dst_mac <= dm;
		in_ch.entry_src_mac <= sm;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic idle_valid();
		in_ch.valid <= 0;
		@(posedge clk);
	endtask

	task automatic fwd_write(logic [5:0] slot, logic [31:0] id, logic ev, logic [15:0] op);
		send(KIND_FWD_WR, $urandom, $urandom, slot, id, ev, op,
			{$urandom, $urandom}, {$urandom, $urandom});
	endtask

	task automatic stat_read(logic [31:0] id);
		send(KIND_STAT_RD, $urandom, $urandom, $urandom, id, $urandom, $urandom,
			{$urandom, $urandom}, {$urandom, $urandom});
	endtask

	// Builds a GTP-U frame into the byte queue; mode picks a defect to inject.
	task automatic build_frame(bit v6, int ihl, logic [31:0] id, int payload, int mode);
		int i;
		int glen;
		frame.delete();
		for (i = 0; i < 12; i++)
			frame.push_back($urandom);
		if (mode == 1) begin
			frame.push_back($urandom);
			frame.push_back($urandom);
		end else if (v6) begin
			frame.push_back(8'h86);
			frame.push_back(8'hDD);
		end else begin
			frame.push_back(8'h08);
			frame.push_back(8'h00);
		end
		if (v6) begin
			for (i = 0; i < 40; i++)
				frame.push_back($urandom);
			frame[14] = {4'h6, 4'($urandom)};
			frame[20] = (mode == 2) ? 8'd6 : IP_PROTO_UDP;
		end else begin
			for (i = 0; i < ihl * 4; i++)
				frame.push_back($urandom);
			frame[14] = {4'h4, 4'(ihl)};
			frame[20] = (mode == 2) ? 8'h20 : {$urandom} & 8'hC0;
			frame[21] = (mode == 2) ? 8'h01 : 8'h00;
			frame[23] = (mode == 3) ? 8'd6 : IP_PROTO_UDP;
		end
		frame.push_back($urandom);
		frame.push_back($urandom);
		frame.push_back(8'h08);
		frame.push_back((mode == 4) ? 8'h69 : 8'h68);
		frame.push_back($urandom);
		frame.push_back($urandom);
		frame.push_back($urandom);
		frame.push_back($urandom);
		frame.push_back((mode == 5) ? 8'h32 : GTP_FLAGS);
		frame.push_back((mode == 6) ? 8'h01 : GTP_TYPE_TPDU);
		glen = (mode == 7) ? payload + 1 : payload;
		frame.push_back(glen[15:8]);
		frame.push_back(glen[7:0]);
		frame.push_back(id[31:24]);
		frame.push_back(id[23:16]);
		frame.push_back(id[15:8]);
		frame.push_back(id[7:0]);
		for (i = 0; i < payload; i++)
			frame.push_back($urandom);
		if (mode == 8)
			frame = frame[0:$urandom_range(0, frame.size() - 2)];
	endtask

	// Sends the frame, sometimes with table writes or reads wedged between bytes.
	task automatic send_frame(bit mix);
		for (int i = 0; i < frame.size(); i++) begin
			if (mix && $urandom_range(0, 15) == 0) begin
				if ($urandom_range(0, 1))
					fwd_write($urandom_range(0, 63), teid_pool[$urandom_range(0, 7)],
						$urandom, port_pool[$urandom_range(0, 3)]);
				else
					stat_read(teid_pool[$urandom_range(0, 7)]);
			end
			send(KIND_FRAME, frame[i], i == frame.size() - 1, $urandom, $urandom,
				$urandom, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
		end
	endtask

	task automatic drain();
		idle_valid();
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_cfg(logic [15:0] v);
		drain();
		cfg_data <= v;
		cfg_we <= 1;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic random_frame();
		int mode;
		mode = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
		build_frame($urandom_range(0, 1), $urandom_range(5, 15),
			teid_pool[$urandom_range(0, 7)], $urandom_range(0, 12), mode);
		send_frame(1);
	endtask

	initial begin
		int n;
		logic [15:0] settings[4];
		cur_ingress = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: table extremes, both IP versions, options, each defect.
		fwd_write(0, 32'h0, 1, 16'hFFFF);
		fwd_write(63, 32'hFFFFFFFF, 1, 16'h0);
		fwd_write(5, 32'h1, 1, 16'h1);
		fwd_write(6, 32'h1, 1, 16'h2);
		cur_ingress = 16'hFFFF;
		build_frame(0, 5, 32'h0, 0, 0); send_frame(0);
		build_frame(1, 5, 32'hFFFFFFFF, 3, 0); send_frame(0);
		build_frame(0, 15, 32'h1, 2, 0); send_frame(0);
		build_frame(0, 5, 32'h12345678, 1, 0); send_frame(0);
		for (int m = 1; m <= 8; m++) begin
			build_frame(m % 2, 5, 32'h1, 1, m);
			send_frame(0);
		end
		build_frame(0, 4, 32'h1, 0, 0); send_frame(0);
		stat_read(32'h1);
		stat_read(32'h0);
		stat_read(32'hDEADBEEF);
		send(KIND_RSVD, 8'hFF, 1, 6'h3F, 32'hFFFFFFFF, 1, 16'hFFFF, '1, '1);

		settings = '{16'hFFFF, 16'h0001, 16'h0, 16'h1234};
		n = 0;
		foreach (settings[k]) begin
			write_cfg(settings[k]);
			for (int j = 0; j < 6; j++) begin
				cur_ingress = ($urandom_range(0, 3) == 0) ? 16'($urandom) : settings[k];
				case ($urandom_range(0, 9))
					0: fwd_write($urandom_range(0, 63), ($urandom_range(0, 7) == 0) ?
						$urandom : teid_pool[$urandom_range(0, 7)], $urandom_range(0, 3) != 0,
						($urandom_range(0, 5) == 0) ? 16'h0 : 16'($urandom));
					1: stat_read(($urandom_range(0, 7) == 0) ? $urandom :
						teid_pool[$urandom_range(0, 7)]);
					2: send(KIND_FRAME, $urandom, $urandom, $urandom, $urandom, $urandom,
						$urandom, {$urandom, $urandom}, {$urandom, $urandom});
					default: random_frame();
				endcase
				n++;
				if (k == 1 && j == 2) begin
					slow_rx = 1;
					hold_left = 2000;
				end
				if (k == 2 && j == 0)
					slow_rx = 0;
			end
			// A random single byte may leave a frame half-parsed; close it out.
			send(KIND_FRAME, 0, 1, 0, 0, 0, 0, 0, 0);
		end
		drain();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
